### src/stable_priority_queue_unit_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/spq_pkg.sv
// Types, codes and helpers for the stable priority queue.
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int PAYLOAD_BITS_DEF = 16;
	localparam int PRIO_W           = 3;
	localparam int TAG_PORT_W       = 16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;
	localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd4;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Broadcast to every cell on an accepted request
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [PRIO_W-1:0] prio;
	} cell_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic              valid;
		logic              keep;
		logic [PRIO_W-1:0] prio;
	} cell_link_t;

	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		logic [PRIO_W-1:0] r;
		if (p < PRIO_MIN)
			r = PRIO_MIN;
		else if (p > PRIO_MAX)
			r = PRIO_MAX;
		else
			r = p;
		return r;
	endfunction

endpackage

### src/spq_cell.sv
// One storage cell of the sorted shift chain.
module spq_cell #(
	parameter int TAG_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic [TAG_W-1:0]   new_tag,
	input  spq_pkg::cell_link_t left_link,
	input  logic [TAG_W-1:0]   left_tag,
	input  spq_pkg::cell_link_t right_link,
	input  logic [TAG_W-1:0]   right_tag,
	output spq_pkg::cell_link_t link,
	output logic [TAG_W-1:0]   tag
);
	import spq_pkg::*;

	logic              valid_q;
	logic [TAG_W-1:0]  tag_q;
	logic [PRIO_W-1:0] prio_q;
	logic              keep;
	logic              valid_d;
	logic [TAG_W-1:0]  tag_d;
	logic [PRIO_W-1:0] prio_d;
	logic              load;

	// Stay put when this entry ranks at or above the newcomer
	assign keep = valid_q && (prio_q >= cmd.prio);

	always_comb begin
		valid_d = valid_q;
		tag_d   = tag_q;
		prio_d  = prio_q;
		load    = 1'b0;
		if (cmd.push && !keep) begin
			load = 1'b1;
			if (left_link.keep) begin
				valid_d = 1'b1;
				tag_d   = new_tag;
				prio_d  = cmd.prio;
			end else begin
				valid_d = left_link.valid;
				tag_d   = left_tag;
				prio_d  = left_link.prio;
			end
		end else if (cmd.pop) begin
			load    = 1'b1;
			valid_d = right_link.valid;
			tag_d   = right_tag;
			prio_d  = right_link.prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= valid_d;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q  <= tag_d;
			prio_q <= prio_d;
		end
	end

	assign link = '{valid: valid_q, keep: keep, prio: prio_q};
	assign tag  = tag_q;

endmodule

### src/stable_priority_queue_unit.sv
// Each accepted request's result is captured in a registered output stage.
// Throughput: one push or pop per cycle while the output is not stalled; every cell
// of the chain compares and shifts in parallel, so the chain settles in the accepting cycle.
// A result not yet taken holds the output register and stalls input.
// Reset clears all cell valid bits (queue empty) and the output valid.
module stable_priority_queue_unit #(
	parameter int QUEUE_DEPTH  = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [spq_pkg::TAG_PORT_W-1:0] payload,
	input  logic [spq_pkg::PRIO_W-1:0]     priority_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [spq_pkg::TAG_PORT_W-1:0] served_payload,
	output logic [spq_pkg::PRIO_W-1:0]     served_priority
);
	import spq_pkg::*;
	`include "stable_priority_queue_unit_macros.svh"

	cell_link_t              links [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] tags  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]  cell_valid;
	cell_cmd_t               cmd;
	logic                    in_fire;
	logic                    empty;
	logic                    full;
	logic [63:0]             in_ext;
	logic [63:0]             head_ext;
	logic [PAYLOAD_BITS-1:0] new_tag;
	status_t                 status_d;
	logic [TAG_PORT_W-1:0]   spay_d;
	logic [PRIO_W-1:0]       sprio_d;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [TAG_PORT_W-1:0]   spay_q;
	logic [PRIO_W-1:0]       sprio_q;

	localparam cell_link_t HEAD_LINK = '{valid: 1'b1, keep: 1'b1, prio: PRIO_MAX};
	localparam cell_link_t TAIL_LINK = '{valid: 1'b0, keep: 1'b0, prio: PRIO_MIN};

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign empty    = !cell_valid[0];
	assign full     = cell_valid[QUEUE_DEPTH-1];

	assign in_ext  = 64'(payload);
	assign new_tag = in_ext[PAYLOAD_BITS-1:0];
	assign head_ext = 64'(tags[0]);

	assign cmd = '{push: in_fire && (op == OP_PUSH) && !full,
	               pop:  in_fire && (op == OP_POP) && !empty,
	               prio: clamp_prio(priority_req)};

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			cell_link_t              l_link;
			logic [PAYLOAD_BITS-1:0] l_tag;
			cell_link_t              r_link;
			logic [PAYLOAD_BITS-1:0] r_tag;

			if (i == 0) begin : g_head
				assign l_link = HEAD_LINK;
				assign l_tag  = new_tag;
			end else begin : g_mid_l
				assign l_link = links[i-1];
				assign l_tag  = tags[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign r_link = TAIL_LINK;
				assign r_tag  = new_tag;
			end else begin : g_mid_r
				assign r_link = links[i+1];
				assign r_tag  = tags[i+1];
			end

			spq_cell #(
				.TAG_W(PAYLOAD_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.new_tag   (new_tag),
				.left_link (l_link),
				.left_tag  (l_tag),
				.right_link(r_link),
				.right_tag (r_tag),
				.link      (links[i]),
				.tag       (tags[i])
			);

			assign cell_valid[i] = links[i].valid;
		end
	endgenerate

	always_comb begin
		spay_d  = '0;
		sprio_d = '0;
		if (op == OP_PUSH) begin
			status_d = full ? ST_FULL : ST_PUSHED;
		end else if (empty) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = ST_POPPED;
			spay_d   = head_ext[TAG_PORT_W-1:0];
			sprio_d  = links[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_ready)
			out_valid_q <= in_fire;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q <= status_d;
			spay_q   <= spay_d;
			sprio_q  <= sprio_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign served_payload  = spay_q;
	assign served_priority = sprio_q;

	// Occupied cells always form one run starting at the head
	`SPQ_ASSERT_ALWAYS(a_thermo, clk, arst_n, ((cell_valid + 1'b1) & cell_valid) == '0)
	`SPQ_ASSERT_NEXT(a_pop_count, clk, arst_n, cmd.pop, $countones(cell_valid) + 1 == $past($countones(cell_valid)))
	`SPQ_ASSERT_NEXT(a_push_count, clk, arst_n, cmd.push, $countones(cell_valid) == $past($countones(cell_valid)) + 1)
	`SPQ_ASSERT_NEXT(a_full_hold, clk, arst_n, in_fire && (op == OP_PUSH) && full, $stable(cell_valid) && status == ST_FULL)

endmodule
